// File: rtl/pgmg_pkg.sv
// shared types and constants of the plane grid mesh generator
package pgmg_pkg;

  localparam int unsigned SEG_W           = 10;
  localparam int unsigned MAX_SEGMENTS_DEF = 1023;
  localparam int unsigned DIVIDEND_W      = 31;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam int unsigned SIZE_W          = 31;
  localparam int unsigned FACTOR_W        = 16;
  localparam int unsigned COORD_W         = 32;
  localparam int unsigned TEX_W           = 17;
  localparam int unsigned IDX_W           = 20;
  localparam int unsigned FRAC_Q14        = 14;

  localparam logic [TEX_W-1:0]    TEX_ONE      = 17'h10000;
  localparam logic [SIZE_W-1:0]   SIZE_RESET   = 31'h0001_0000;
  localparam logic [SEG_W-1:0]    SEG_RESET    = 10'd1;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'h4000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_WIDTH  = 3'd0,
    CFG_PLANE_HEIGHT = 3'd1,
    CFG_COLUMNS      = 3'd2,
    CFG_ROWS         = 3'd3,
    CFG_UP_AXIS      = 3'd4,
    CFG_UP_FACTOR    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic {
    KIND_VERTEX   = 1'b0,
    KIND_TRIANGLE = 1'b1
  } kind_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: rtl/pgmg_divider.sv
// restoring serial divider, one quotient bit per cycle
module pgmg_divider #(
  parameter int unsigned DIVIDEND_W = pgmg_pkg::DIVIDEND_W,
  parameter int unsigned DIVISOR_W  = pgmg_pkg::SEG_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [DIVIDEND_W-1:0]  dividend_i,
  input  logic [DIVISOR_W-1:0]   divisor_i,
  output logic [DIVIDEND_W-1:0]  quotient_o,
  output pgmg_pkg::div_status_t  status_o
);

  localparam int unsigned IT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                  busy_q;
  logic                  done_q;
  logic [IT_W-1:0]       cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dsr_q;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  always_comb begin
    trial = {rem_q, quo_q[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = (trial >= {1'b0, dsr_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= IT_W'(DIVIDEND_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits the divisor width
      rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

`ifndef SYNTHESIS
  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a running division");
  a_no_restart_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider started while busy");
  a_rem_below_dsr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && $past(busy_q)) |-> (rem_q < dsr_q))
    else $error("divider remainder not below divisor");
`endif

endmodule

// File: rtl/plane_grid_mesh_generator.sv
// plane grid mesh generator: one grid point per input transfer, up to three results
// a new input is taken only in idle, after the last result of the point is loaded; output stalls
//   hold the results, and the serial divider gives two texture quotients per point, two more at restart
// the position multiplier is shared across three products, one per step of the sequencer
// reset: idle with the mesh finished, config at its reset values, no result pending
module plane_grid_mesh_generator #(
  parameter int unsigned MAX_SEGMENTS = pgmg_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pgmg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pgmg_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 restart_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 kind_o,
  output logic signed [pgmg_pkg::COORD_W-1:0]  coord_x_o,
  output logic signed [pgmg_pkg::COORD_W-1:0]  coord_y_o,
  output logic signed [pgmg_pkg::COORD_W-1:0]  coord_z_o,
  output logic [pgmg_pkg::TEX_W-1:0]           tex_u_o,
  output logic [pgmg_pkg::TEX_W-1:0]           tex_v_o,
  output logic [pgmg_pkg::IDX_W-1:0]           corner_a_o,
  output logic [pgmg_pkg::IDX_W-1:0]           corner_b_o,
  output logic [pgmg_pkg::IDX_W-1:0]           corner_c_o,
  output logic                                 mesh_done_o,
  output logic                                 last_o
);

  localparam int unsigned CNT_FULL = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned CNT_W    = (CNT_FULL > pgmg_pkg::SEG_W) ? pgmg_pkg::SEG_W : CNT_FULL;
  localparam int unsigned DIV_W    = pgmg_pkg::DIVIDEND_W;
  localparam int unsigned MUL_A_W  = 43;
  localparam int unsigned MUL_B_W  = 17;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned SC_W     = PROD_W - pgmg_pkg::FRAC_Q14;
  localparam int unsigned CW       = pgmg_pkg::COORD_W;
  localparam int unsigned IW       = pgmg_pkg::IDX_W;
  localparam int unsigned TW       = pgmg_pkg::TEX_W;
  localparam int unsigned ROUND_BIAS = 1 << (pgmg_pkg::FRAC_Q14 - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_STEP_X, S_STEP_Y, S_MUL_X, S_MUL_Y, S_POS_X, S_POS_Y,
    S_SCALE, S_SCALE_W, S_ROUND, S_TEX_U, S_TEX_V,
    S_EMIT_VTX, S_EMIT_TRI0, S_EMIT_TRI1
  } state_e;

  function automatic logic signed [CW-1:0] sat32(input logic signed [SC_W-1:0] v);
    logic signed [CW-1:0] r;
    if ((&v[SC_W-1:CW-1]) || !(|v[SC_W-1:CW-1])) begin
      r = v[CW-1:0];
    end else if (v[SC_W-1]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  state_e state_q;

  // configuration
  logic [pgmg_pkg::SIZE_W-1:0]          plane_width_q, plane_height_q;
  logic [pgmg_pkg::SEG_W-1:0]           columns_q, rows_q;
  logic [1:0]                           up_axis_q;
  logic signed [pgmg_pkg::FACTOR_W-1:0] up_factor_q;

  // walk state
  logic [CNT_W-1:0] col_q, row_q;
  logic [IW-1:0]    vidx_q;
  logic             finished_q;

  // datapath
  logic [DIV_W-1:0]          step_x_q, step_y_q;
  logic signed [MUL_A_W-1:0] mul_a_q;
  logic signed [MUL_B_W-1:0] mul_b_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [MUL_A_W-1:0] x_q, y_q;
  logic signed [SC_W-1:0]    sc_q;
  logic [TW-1:0]             u_q, v_q;

  // output register
  logic                 out_valid_q;
  logic                 kind_q;
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic [TW-1:0]        tu_q, tv_q;
  logic [IW-1:0]        ca_q, cb_q, cc_q;
  logic                 done_q, last_q;

  // divider hookup
  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic [CNT_W-1:0]      div_divisor;
  logic [DIV_W-1:0]      div_quo;
  pgmg_pkg::div_status_t div_st;

  logic [CNT_W-1:0]      cols_eff, rows_eff;
  logic                  accept_in, out_free, emit_state, emit_fire, emit_last;
  logic                  is_tri, is_done;
  logic [IW-1:0]         stride;
  logic                  scale_neg;
  logic signed [PROD_W-1:0] scale_sum;
  logic signed [CW-1:0]  pos_x, pos_y, pos_z;
  logic [TW-1:0]         tex_sat;

  always_comb begin
    if (columns_q == '0) begin
      cols_eff = CNT_W'(1);
    end else if (32'(columns_q) > MAX_SEGMENTS) begin
      cols_eff = CNT_W'(MAX_SEGMENTS);
    end else begin
      cols_eff = CNT_W'(columns_q);
    end
    if (rows_q == '0) begin
      rows_eff = CNT_W'(1);
    end else if (32'(rows_q) > MAX_SEGMENTS) begin
      rows_eff = CNT_W'(MAX_SEGMENTS);
    end else begin
      rows_eff = CNT_W'(rows_q);
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept_in   = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign emit_state  = state_q inside {S_EMIT_VTX, S_EMIT_TRI0, S_EMIT_TRI1};
  assign emit_fire   = emit_state && out_free;
  assign is_tri      = (row_q < rows_eff) && (col_q < cols_eff);
  assign is_done     = (row_q >= rows_eff) && (col_q >= cols_eff);
  assign emit_last   = emit_fire &&
                       ((state_q == S_EMIT_TRI1) || ((state_q == S_EMIT_VTX) && !is_tri));
  assign stride      = IW'(cols_eff) + IW'(1);

  // divider requests: steps at restart, then texture u and v per point
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = cols_eff;
    case (state_q)
      S_IDLE: begin
        div_start    = accept_in && restart_i;
        div_dividend = DIV_W'(plane_width_q);
      end
      S_STEP_X: begin
        div_start    = div_st.done;
        div_dividend = DIV_W'(plane_height_q);
        div_divisor  = rows_eff;
      end
      S_MUL_X: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'({col_q, 16'h0000});
      end
      S_TEX_U: begin
        div_start    = div_st.done;
        div_dividend = DIV_W'({row_q, 16'h0000});
        div_divisor  = rows_eff;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  pgmg_divider #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (CNT_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .status_o   (div_st)
  );

  assign tex_sat = (div_quo > DIV_W'(pgmg_pkg::TEX_ONE)) ? pgmg_pkg::TEX_ONE : div_quo[TW-1:0];

  // placement and rounding of the scaled coordinate
  always_comb begin
    scale_neg = (up_axis_q == pgmg_pkg::AXIS_X) || (up_axis_q == pgmg_pkg::AXIS_Y);
    scale_sum = (scale_neg ? -prod_q : prod_q) + PROD_W'(ROUND_BIAS);
    case (up_axis_q)
      pgmg_pkg::AXIS_X: begin
        pos_x = '0;
        pos_y = sat32(SC_W'(y_q));
        pos_z = sat32(sc_q);
      end
      pgmg_pkg::AXIS_Y: begin
        pos_x = sat32(SC_W'(x_q));
        pos_y = '0;
        pos_z = sat32(sc_q);
      end
      default: begin
        pos_x = sat32(sc_q);
        pos_y = sat32(SC_W'(y_q));
        pos_z = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      out_valid_q    <= 1'b0;
      col_q          <= '0;
      row_q          <= '0;
      vidx_q         <= '0;
      finished_q     <= 1'b1;
      plane_width_q  <= pgmg_pkg::SIZE_RESET;
      plane_height_q <= pgmg_pkg::SIZE_RESET;
      columns_q      <= pgmg_pkg::SEG_RESET;
      rows_q         <= pgmg_pkg::SEG_RESET;
      up_axis_q      <= pgmg_pkg::AXIS_Z;
      up_factor_q    <= pgmg_pkg::FACTOR_RESET;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (pgmg_pkg::cfg_idx_e'(cfg_index_i))
          pgmg_pkg::CFG_PLANE_WIDTH:  plane_width_q  <= cfg_data_i[pgmg_pkg::SIZE_W-1:0];
          pgmg_pkg::CFG_PLANE_HEIGHT: plane_height_q <= cfg_data_i[pgmg_pkg::SIZE_W-1:0];
          pgmg_pkg::CFG_COLUMNS:      columns_q      <= cfg_data_i[pgmg_pkg::SEG_W-1:0];
          pgmg_pkg::CFG_ROWS:         rows_q         <= cfg_data_i[pgmg_pkg::SEG_W-1:0];
          pgmg_pkg::CFG_UP_AXIS:      up_axis_q      <= cfg_data_i[1:0];
          pgmg_pkg::CFG_UP_FACTOR:    up_factor_q    <= cfg_data_i[pgmg_pkg::FACTOR_W-1:0];
          default: begin
          end
        endcase
      end

      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept_in) begin
            if (restart_i) begin
              col_q      <= '0;
              row_q      <= '0;
              vidx_q     <= '0;
              finished_q <= 1'b0;
              state_q    <= S_STEP_X;
            end else if (!finished_q) begin
              state_q <= S_MUL_X;
            end
          end
        end
        S_STEP_X:  if (div_st.done) state_q <= S_STEP_Y;
        S_STEP_Y:  if (div_st.done) state_q <= S_MUL_X;
        S_MUL_X:   state_q <= S_MUL_Y;
        S_MUL_Y:   state_q <= S_POS_X;
        S_POS_X:   state_q <= S_POS_Y;
        S_POS_Y:   state_q <= S_SCALE;
        S_SCALE:   state_q <= S_SCALE_W;
        S_SCALE_W: state_q <= S_ROUND;
        S_ROUND:   state_q <= S_TEX_U;
        S_TEX_U:   if (div_st.done) state_q <= S_TEX_V;
        S_TEX_V:   if (div_st.done) state_q <= S_EMIT_VTX;
        S_EMIT_VTX: begin
          if (out_free && is_tri) state_q <= S_EMIT_TRI0;
        end
        S_EMIT_TRI0: begin
          if (out_free) state_q <= S_EMIT_TRI1;
        end
        default: begin
        end
      endcase

      // the final result of the point is loaded: advance the walk
      if (emit_last) begin
        state_q <= S_IDLE;
        vidx_q  <= vidx_q + 1'b1;
        if (is_done) begin
          finished_q <= 1'b1;
        end else if (col_q >= cols_eff) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  // shared multiplier, one product per step
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a_q * mul_b_q;
    case (state_q)
      S_STEP_X: if (div_st.done) step_x_q <= div_quo;
      S_STEP_Y: if (div_st.done) step_y_q <= div_quo;
      S_MUL_X: begin
        mul_a_q <= MUL_A_W'(step_x_q);
        mul_b_q <= MUL_B_W'(col_q);
      end
      S_MUL_Y: begin
        mul_a_q <= MUL_A_W'(step_y_q);
        mul_b_q <= MUL_B_W'(row_q);
      end
      S_POS_X: x_q <= prod_q[MUL_A_W-1:0] - MUL_A_W'(plane_width_q[pgmg_pkg::SIZE_W-1:1]);
      S_POS_Y: y_q <= prod_q[MUL_A_W-1:0] - MUL_A_W'(plane_height_q[pgmg_pkg::SIZE_W-1:1]);
      S_SCALE: begin
        mul_a_q <= (up_axis_q == pgmg_pkg::AXIS_Y) ? y_q : x_q;
        mul_b_q <= MUL_B_W'(up_factor_q);
      end
      // upper bits of the biased sum give the floor of the q14 shift
      S_ROUND: sc_q <= scale_sum[PROD_W-1:pgmg_pkg::FRAC_Q14];
      S_TEX_U: if (div_st.done) u_q <= tex_sat;
      S_TEX_V: if (div_st.done) v_q <= tex_sat;
      default: begin
      end
    endcase

    if (emit_fire) begin
      done_q <= is_done;
      last_q <= emit_last;
      ca_q   <= vidx_q;
      if (state_q == S_EMIT_VTX) begin
        kind_q <= pgmg_pkg::KIND_VERTEX;
        cx_q   <= pos_x;
        cy_q   <= pos_y;
        cz_q   <= pos_z;
        tu_q   <= u_q;
        tv_q   <= v_q;
        cb_q   <= '0;
        cc_q   <= '0;
      end else begin
        kind_q <= pgmg_pkg::KIND_TRIANGLE;
        cx_q   <= '0;
        cy_q   <= '0;
        cz_q   <= '0;
        tu_q   <= '0;
        tv_q   <= '0;
        if (state_q == S_EMIT_TRI0) begin
          cb_q <= vidx_q + IW'(1);
          cc_q <= vidx_q + stride + IW'(1);
        end else begin
          cb_q <= vidx_q + stride + IW'(1);
          cc_q <= vidx_q + stride;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign coord_x_o   = cx_q;
  assign coord_y_o   = cy_q;
  assign coord_z_o   = cz_q;
  assign tex_u_o     = tu_q;
  assign tex_v_o     = tv_q;
  assign corner_a_o  = ca_q;
  assign corner_b_o  = cb_q;
  assign corner_c_o  = cc_q;
  assign mesh_done_o = done_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_busy_not_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> !in_ready_o) else $error("input ready while divider busy");
  a_tri_zero_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == pgmg_pkg::KIND_TRIANGLE)) |->
    (coord_x_o == '0 && coord_y_o == '0 && coord_z_o == '0 && tex_u_o == '0 && tex_v_o == '0))
    else $error("triangle result carries vertex data");
  a_vtx_zero_corner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == pgmg_pkg::KIND_VERTEX)) |->
    (corner_b_o == '0 && corner_c_o == '0)) else $error("vertex result carries corners");
  a_tex_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tex_u_o <= pgmg_pkg::TEX_ONE && tex_v_o <= pgmg_pkg::TEX_ONE))
    else $error("texture coordinate above one");
`endif

endmodule
